### src/ssbs_pkg.sv
// ----------------------------------------------------------------------------
// ssbs_pkg - sorted store with binary search, shared types and constants
// Item layouts, request codes and the broadcast bundle that drives the cells.
// ----------------------------------------------------------------------------
package ssbs_pkg;

  localparam int ValW = 32;
  localparam int PosW = 4;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef struct packed {
    logic                   req_type;
    logic signed [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
  } res_t;

  // Broadcast from the top level to every cell of the chain
  typedef struct packed {
    logic                   load;
    logic                   probe;
    logic signed [ValW-1:0] data;
  } bcast_t;

endpackage

### src/ssbs_cell.sv
// ----------------------------------------------------------------------------
// ssbs_cell - one slot of the sorted chain
// Holds one element. On a load it keeps its element, takes the new value or
// takes its left neighbor's element; on a search it latches its compare flags.
// ----------------------------------------------------------------------------
module ssbs_cell
  import ssbs_pkg::*;
(
  input  logic                   clk_i,
  input  bcast_t                 bcast_i,
  input  logic                   occ_i,
  input  logic                   left_le_i,
  input  logic signed [ValW-1:0] left_val_i,
  output logic signed [ValW-1:0] val_o,
  output logic                   le_o,
  output logic                   le_flag_o,
  output logic                   eq_flag_o
);

  logic signed [ValW-1:0] val_q, val_d;
  logic                   le_flag_q, le_flag_d;
  logic                   eq_flag_q, eq_flag_d;
  logic                   le_raw;

  assign le_raw = (val_q <= bcast_i.data);
  assign le_o   = occ_i && le_raw;

  always_comb begin
    val_d     = val_q;
    le_flag_d = le_flag_q;
    eq_flag_d = eq_flag_q;
    if (bcast_i.load && !le_o) begin
      // shift right past the insertion point, drop the new value at it
      val_d = left_le_i ? bcast_i.data : left_val_i;
    end
    if (bcast_i.probe) begin
      le_flag_d = le_raw;
      eq_flag_d = (val_q == bcast_i.data);
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    le_flag_q <= le_flag_d;
    eq_flag_q <= eq_flag_d;
  end

  assign val_o     = val_q;
  assign le_flag_o = le_flag_q;
  assign eq_flag_o = eq_flag_q;

endmodule

### src/ssbs_seq.sv
// ----------------------------------------------------------------------------
// ssbs_seq - binary search sequencer
// Walks the latched per-cell compare flags with low/high bounds, one probe
// per cycle, and issues one result item per search.
// ----------------------------------------------------------------------------
module ssbs_seq
  import ssbs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic [$clog2(DEPTH+1)-1:0]   fill_i,
  input  logic [DEPTH-1:0]             le_flags_i,
  input  logic [DEPTH-1:0]             eq_flags_i,
  output logic                         busy_o,
  output logic                         done_o,
  output res_t                         res_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic          state_q, state_d;
  logic [CW-1:0] low_q, low_d;
  logic [CW-1:0] hiex_q, hiex_d;   // exclusive upper bound
  logic          done_q, done_d;
  res_t          res_q, res_d;

  logic [CW:0]      sum;
  logic [CW-1:0]    mid;
  logic [IW-1:0]    midx;
  logic [CW+PosW-1:0] mid_ext;
  logic             empty;

  always_comb begin
    sum     = {1'b0, low_q} + {1'b0, hiex_q} - (CW+1)'(1);
    mid     = sum[CW:1];
    midx    = mid[IW-1:0];
    mid_ext = {{PosW{1'b0}}, mid};
    empty   = !(low_q < hiex_q);
  end

  always_comb begin
    state_d = state_q;
    low_d   = low_q;
    hiex_d  = hiex_q;
    done_d  = 1'b0;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (go_i) begin
          low_d   = '0;
          hiex_d  = fill_i;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (empty) begin
          done_d         = 1'b1;
          res_d.found    = 1'b0;
          res_d.position = '0;
          state_d        = S_IDLE;
        end else if (eq_flags_i[midx]) begin
          done_d         = 1'b1;
          res_d.found    = 1'b1;
          res_d.position = mid_ext[PosW-1:0];
          state_d        = S_IDLE;
        end else if (!le_flags_i[midx]) begin
          // key below the probed element
          hiex_d = mid;
        end else begin
          low_d = mid + CW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q  <= low_d;
    hiex_q <= hiex_d;
    res_q  <= res_d;
  end

  assign busy_o = (state_q == S_RUN);
  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_RUN))
    else $error("result strobe without a running search");

  a_bound_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (hiex_q <= fill_i) && (low_q <= fill_i))
    else $error("search bounds left the filled part of the store");

  a_miss_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.found) |-> (res_o.position == '0))
    else $error("miss reported with nonzero position");

endmodule

### src/sorted_store_binary_search_top.sv
// ----------------------------------------------------------------------------
// sorted_store_binary_search_top - sorted store with binary search
// Keeps signed values in ascending order in a chain of cells and answers
// search items with a found flag and sorted position.
// ----------------------------------------------------------------------------
// A load item (req_type 0) is inserted in the cycle it is accepted, after any
// equal values, and busy stays low, so loads can follow each other every
// cycle; a load into a full store starts a new set holding only that value.
// A search item (req_type 1) makes every cell latch its compare flags at the
// accepting edge; the sequencer then probes one position per cycle, and busy
// stays high while the search runs. The result is shown on res_o with done_o
// for exactly one cycle, the first cycle after the last busy cycle; it
// cannot be held off, and a new item may be accepted while it is shown.
// Loads produce no result item.
// ----------------------------------------------------------------------------
module sorted_store_binary_search_top
  import ssbs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] fill_eff;
  logic          accept;
  logic          do_load;
  logic          do_search;
  bcast_t        bcast;

  logic signed [ValW-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]       cell_le;
  logic [DEPTH-1:0]       le_flags;
  logic [DEPTH-1:0]       eq_flags;

  assign accept    = start && !busy;
  assign do_load   = accept && (req_i.req_type == REQ_LOAD);
  assign do_search = accept && (req_i.req_type == REQ_SEARCH);

  // a full store restarts from empty on the next load
  assign fill_eff = (fill_q == CW'(DEPTH)) ? '0 : fill_q;

  always_comb begin
    bcast.load  = do_load;
    bcast.probe = do_search;
    bcast.data  = req_i.value;
    fill_d      = fill_q;
    if (do_load) begin
      fill_d = fill_eff + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic                   left_le;
    logic signed [ValW-1:0] left_val;
    if (k == 0) begin : g_head
      assign left_le  = 1'b1;
      assign left_val = req_i.value;
    end else begin : g_body
      assign left_le  = cell_le[k-1];
      assign left_val = cell_val[k-1];
    end
    ssbs_cell u_cell (
      .clk_i      (clk_i),
      .bcast_i    (bcast),
      .occ_i      (CW'(k) < fill_eff),
      .left_le_i  (left_le),
      .left_val_i (left_val),
      .val_o      (cell_val[k]),
      .le_o       (cell_le[k]),
      .le_flag_o  (le_flags[k]),
      .eq_flag_o  (eq_flags[k])
    );
  end

  ssbs_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (do_search),
    .fill_i     (fill_q),
    .le_flags_i (le_flags),
    .eq_flags_i (eq_flags),
    .busy_o     (busy),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("fill count beyond store depth");

  a_fill_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> $stable(fill_q))
    else $error("store changed during a search");

  for (genvar k = 0; k + 1 < DEPTH; k++) begin : g_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (CW'(k + 1) < fill_q) |-> (cell_val[k] <= cell_val[k+1]))
      else $error("held elements out of order");
  end

endmodule

### verif/ssbs_search_checker.sv
// ----------------------------------------------------------------------------
// ssbs_search_checker - result checker for the sorted store with binary search
// Watches the request and result channels, keeps its own sorted copy of the
// loaded values, works out the answer to every accepted search and compares
// each strobed result against the oldest outstanding answer.
// ----------------------------------------------------------------------------
module ssbs_search_checker
  import ssbs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic done_i,
  input  res_t res_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   loads_o,
  output int   restarts_o,
  output int   searches_o,
  output int   hits_o
);

  logic signed [ValW-1:0] held_vals [DEPTH];
  int                     held_cnt;
  res_t                   answer_q [$];

  // Insert after any equal values; a full store starts a new set first.
  function automatic void insert_sorted(input logic signed [ValW-1:0] v);
    int pos;
    int k;
    if (held_cnt >= DEPTH) begin
      held_cnt = 0;
      restarts_o++;
    end
    pos = 0;
    while (pos < held_cnt && held_vals[pos] <= v) pos++;
    for (k = held_cnt; k > pos; k--) held_vals[k] = held_vals[k-1];
    held_vals[pos] = v;
    held_cnt++;
  endfunction

  // Probe order: mid = floor((lo + hi) / 2), stop at the first equal element.
  function automatic res_t search_answer(input logic signed [ValW-1:0] key);
    int   lo;
    int   hi;
    int   mid;
    res_t ans;
    ans = '0;
    lo  = 0;
    hi  = held_cnt - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key < held_vals[mid]) begin
        hi = mid - 1;
      end else if (key > held_vals[mid]) begin
        lo = mid + 1;
      end else begin
        ans.found    = 1'b1;
        ans.position = mid[PosW-1:0];
        return ans;
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      held_cnt = 0;
      answer_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      loads_o      = 0;
      restarts_o   = 0;
      searches_o   = 0;
      hits_o       = 0;
    end else begin
      // A result shown now belongs to an earlier item, so check it first.
      if (done_i) begin
        if (answer_q.size() == 0) begin
          $error("result with no search outstanding: found=%0b position=%0d",
                 res_i.found, res_i.position);
          fail_count_o++;
        end else begin
          want = answer_q.pop_front();
          if (res_i.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, res_i.found);
            fail_count_o++;
          end
          if (res_i.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, res_i.position);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (req_i.req_type == REQ_LOAD) begin
          insert_sorted(req_i.value);
          loads_o++;
        end else begin
          want = search_answer(req_i.value);
          answer_q.push_back(want);
          searches_o++;
          if (want.found) hits_o++;
        end
      end
      pending_o = answer_q.size();
    end
  end

endmodule

### verif/sorted_store_binary_search_top_tb.sv
// ----------------------------------------------------------------------------
// sorted_store_binary_search_top_tb - testbench for the sorted search store
// Drives a directed sequence of loads and searches (extremes, duplicates,
// empty store, full-store restart) and then a long random mix with idle gaps;
// a separate checker predicts and compares every search result.
// ----------------------------------------------------------------------------
module sorted_store_binary_search_top_tb
  import ssbs_pkg::*;
();

  localparam int DEPTH        = 16;
  localparam int N_RANDOM     = 1025;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 12;

  localparam logic signed [ValW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ValW-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req;
  logic done;
  res_t res;

  int fail_count;
  int pending;
  int n_loads;
  int n_restarts;
  int n_searches;
  int n_hits;
  int idle_cycles;

  logic signed [ValW-1:0] recent_vals [DEPTH];
  int                     n_recent;
  int                     recent_wr;

  sorted_store_binary_search_top #(
    .DEPTH (DEPTH)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .res_o  (res)
  );

  ssbs_search_checker #(
    .DEPTH (DEPTH)
  ) u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .done_i       (done),
    .res_i        (res),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .loads_o      (n_loads),
    .restarts_o   (n_restarts),
    .searches_o   (n_searches),
    .hits_o       (n_hits)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Reset the count whenever an item or a result moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold the item until the block takes it.
  task automatic send_item(input logic rt, input logic signed [ValW-1:0] v);
    @(negedge clk_i);
    start <= 1'b1;
    req   <= '{req_type: rt, value: v};
    do @(posedge clk_i); while (busy);
    if (rt == REQ_LOAD) begin
      recent_vals[recent_wr] = v;
      recent_wr = (recent_wr + 1) % DEPTH;
      if (n_recent < DEPTH) n_recent++;
    end
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [ValW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return int'($urandom_range(0, 20)) - 10;
    if (r < 85) return $urandom;
    case ($urandom_range(0, 3))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_MIN + 1;
      default: return VAL_MAX - 1;
    endcase
  endfunction

  function automatic logic signed [ValW-1:0] pick_key();
    if (n_recent > 0 && $urandom_range(0, 99) < 60)
      return recent_vals[$urandom_range(0, n_recent - 1)];
    return pick_value();
  endfunction

  // Mostly back to back or short gaps, a few long ones; some stretches with none.
  function automatic int pick_gap(input int idx);
    int unsigned r;
    if ((idx / 64) % 4 == 3) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    start       = 1'b0;
    req         = '0;
    rst_ni      = 1'b0;
    idle_cycles = 0;
    n_recent    = 0;
    recent_wr   = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty store, extremes, duplicates
    send_item(REQ_SEARCH, 5);
    send_item(REQ_LOAD, VAL_MIN);
    send_item(REQ_LOAD, VAL_MAX);
    send_item(REQ_LOAD, -1);
    send_item(REQ_LOAD, 7);
    send_item(REQ_LOAD, 7);
    send_item(REQ_LOAD, 7);
    send_item(REQ_SEARCH, VAL_MIN);
    send_item(REQ_SEARCH, VAL_MAX);
    send_item(REQ_SEARCH, 7);
    send_item(REQ_SEARCH, -1);
    send_item(REQ_SEARCH, 0);
    // fill to the top, then a load that starts a new set
    for (int i = 0; i < DEPTH - 6; i++) send_item(REQ_LOAD, i * 3 - 12);
    send_item(REQ_LOAD, 100);
    send_item(REQ_SEARCH, 7);
    send_item(REQ_SEARCH, 100);
    wait_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 150 == 149) wait_drained();
      idle_for(pick_gap(i));
      if ($urandom_range(0, 99) < 55) send_item(REQ_LOAD, pick_value());
      else                            send_item(REQ_SEARCH, pick_key());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d loads with %0d full-store restarts and %0d searches (%0d hits).",
             n_loads, n_restarts, n_searches, n_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
